// ----- hw/rtl/ps2sc_pkg.sv -----
// Package: payload types, ring/decoder control structs, scancode ROM
`default_nettype none
package ps2sc_pkg;

  localparam int RING_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    OP_SCAN = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [7:0]  CODE_EXT     = 8'hE0;
  localparam logic [6:0]  CODE_LSHIFT  = 7'h2A;
  localparam logic [6:0]  CODE_RSHIFT  = 7'h36;
  localparam logic [6:0]  CODE_ALT     = 7'h38;
  localparam logic [6:0]  CODE_CTRL    = 7'h1D;
  localparam logic [7:0]  CHAR_PREFIX  = 8'h01;
  localparam int          TABLE_LEN    = 92;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } ps2sc_in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       read_valid;
    logic [1:0] pushed_count;
    logic       dropped;
    logic       shift_down;
    logic       ctrl_down;
    logic       alt_down;
  } ps2sc_out_t;

  // what the decoder wants pushed for the current byte
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] first;
    logic [7:0] second;
  } dec_push_t;

  typedef struct packed {
    logic       push;
    logic [7:0] push_data;
    logic       pop;
  } ring_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

  localparam logic [15:0] LOW_PLAIN [0:TABLE_LEN-1] = '{
    16'h0000,
    16'h001B, 16'h0031, 16'h0032, 16'h0033, 16'h0034,
    16'h0035, 16'h0036, 16'h0037, 16'h0038, 16'h0039,
    16'h0030, 16'h002D, 16'h003D, 16'h0008, 16'h0009,
    16'h0071, 16'h0077, 16'h0065, 16'h0072, 16'h0074,
    16'h0079, 16'h0075, 16'h0069, 16'h006F, 16'h0070,
    16'h005B, 16'h005D, 16'h000A, 16'h0000, 16'h0061,
    16'h0073, 16'h0064, 16'h0066, 16'h0067, 16'h0068,
    16'h006A, 16'h006B, 16'h006C, 16'h003B, 16'h0027,
    16'h0060, 16'h0000, 16'h005C, 16'h007A, 16'h0078,
    16'h0063, 16'h0076, 16'h0062, 16'h006E, 16'h006D,
    16'h002C, 16'h002E, 16'h002F, 16'h0000, 16'h002A,
    16'h0000, 16'h0020, 16'h0000, 16'hF03B, 16'hF03C,
    16'hF03D, 16'hF03E, 16'hF03F, 16'hF040, 16'hF041,
    16'hF042, 16'hF043, 16'hF044, 16'h0000, 16'h0000,
    16'hF047, 16'hF072, 16'hF049, 16'h002D, 16'hF04B,
    16'h0000, 16'hF077, 16'h002B, 16'hF04F, 16'hF080,
    16'hF051, 16'hF052, 16'hF053, 16'h0000, 16'h0000,
    16'h005C, 16'hF085, 16'hF086, 16'h0000, 16'h0000,
    16'h0000
  };

  localparam logic [15:0] LOW_SHIFTED [0:TABLE_LEN-1] = '{
    16'h0000,
    16'h001B, 16'h0021, 16'h0040, 16'h0023, 16'h0024,
    16'h0025, 16'h005E, 16'h0026, 16'h002A, 16'h0028,
    16'h0029, 16'h005F, 16'h002B, 16'h0008, 16'h0015,
    16'h0051, 16'h0057, 16'h0045, 16'h0052, 16'h0054,
    16'h0059, 16'h0055, 16'h0049, 16'h004F, 16'h0050,
    16'h007B, 16'h007D, 16'h000D, 16'h0000, 16'h0041,
    16'h0053, 16'h0044, 16'h0046, 16'h0047, 16'h0048,
    16'h004A, 16'h004B, 16'h004C, 16'h003A, 16'h0022,
    16'h007E, 16'h0000, 16'h007C, 16'h005A, 16'h0058,
    16'h0043, 16'h0056, 16'h0042, 16'h004E, 16'h004D,
    16'h003C, 16'h003E, 16'h003F, 16'h0000, 16'h002A,
    16'h0000, 16'h0020, 16'h0000, 16'hF054, 16'hF055,
    16'hF056, 16'hF057, 16'hF058, 16'hF059, 16'hF05A,
    16'hF05B, 16'hF05C, 16'hF05D, 16'h0000, 16'h0000,
    16'hF047, 16'hF072, 16'hF049, 16'h002D, 16'hF04B,
    16'h0000, 16'hF077, 16'h002B, 16'hF04F, 16'hF080,
    16'hF051, 16'hF052, 16'hF053, 16'h0000, 16'h0000,
    16'h005C, 16'hF087, 16'hF088, 16'h0000, 16'h0000,
    16'h0000
  };

  // codes above the table share one entry set for both shift states
  function automatic logic [15:0] rom_entry(input logic shifted, input logic [7:0] code);
    logic [15:0] e;
    if (code < 8'(TABLE_LEN)) begin
      e = shifted ? LOW_SHIFTED[code[6:0]] : LOW_PLAIN[code[6:0]];
    end else begin
      unique case (code)
        8'hC8:   e = 16'hF072;
        8'hCB:   e = 16'hF04B;
        8'hCD:   e = 16'hF077;
        8'hD0:   e = 16'hF080;
        default: e = 16'hFE00 + 16'(code - 8'(TABLE_LEN));
      endcase
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ps2_scancode_to_char_fifo.sv -----
// Top level: PS/2 set 1 decoder feeding a character ring
//
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_data  (operation, data_byte)
// out     | out | out_valid / out_ready| out_data (read_char .. alt_down)
//
// An accepted item is handled in order: the accept edge does the first ring
// transfer (push, or issue the registered pop read), and the finish edge does the
// second push of a two-byte key or captures the popped byte, and loads the
// output register. The single ring write port is why the second push waits.
// Reset (rst, synchronous) empties the ring and clears all modifier flags.
// A full output register holds the busy item until out_ready; in_ready stays low.
`default_nettype none
module ps2_scancode_to_char_fifo #(
  parameter int RING_DEPTH = ps2sc_pkg::RING_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ps2sc_pkg::ps2sc_in_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ps2sc_pkg::ps2sc_out_t     out_data
);

  ps2sc_pkg::dec_push_t  dec;
  ps2sc_pkg::ring_req_t  req;
  ps2sc_pkg::ring_stat_t stat;
  logic [7:0] rd_data;
  logic       shift_down, ctrl_down, alt_down;

  // item state held while busy
  logic       busy;
  logic       pop_ok;
  logic       pushed;
  logic       lost;
  logic       sec_pend;
  logic [7:0] sec_byte;

  logic accept;
  logic out_free;
  logic finish;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign finish   = busy && out_free;

  ps2sc_decode u_dec (
    .clk        (clk),
    .rst        (rst),
    .scan_en    (accept && in_data.operation == ps2sc_pkg::OP_SCAN),
    .scan_byte  (in_data.data_byte),
    .push_info  (dec),
    .shift_down (shift_down),
    .ctrl_down  (ctrl_down),
    .alt_down   (alt_down)
  );

  ps2sc_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .stat    (stat),
    .rd_data (rd_data)
  );

  // ring request: second push while busy, else the accepted item's transfer
  always_comb begin
    req = '0;
    if (busy) begin
      req.push      = sec_pend && finish;
      req.push_data = sec_byte;
    end else if (accept) begin
      unique case (in_data.operation)
        ps2sc_pkg::OP_SCAN: begin
          req.push      = (dec.count != 2'd0);
          req.push_data = dec.first;
        end
        ps2sc_pkg::OP_PUSH: begin
          req.push      = 1'b1;
          req.push_data = in_data.data_byte;
        end
        ps2sc_pkg::OP_POP: req.pop = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_ok   <= req.pop && !stat.empty;
      pushed   <= req.push && !stat.full;
      lost     <= req.push && stat.full;
      sec_pend <= (in_data.operation == ps2sc_pkg::OP_SCAN) && (dec.count == 2'd2);
      sec_byte <= dec.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.read_char    <= pop_ok ? rd_data : 8'h00;
      out_data.read_valid   <= pop_ok;
      out_data.pushed_count <= {1'b0, pushed} + {1'b0, sec_pend && !stat.full};
      out_data.dropped      <= lost || (sec_pend && stat.full);
      out_data.shift_down   <= shift_down;
      out_data.ctrl_down    <= ctrl_down;
      out_data.alt_down     <= alt_down;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ps2sc_decode.sv -----
// Scancode set 1 decoder: extended prefix, modifier flags, ROM lookup
`default_nettype none
module ps2sc_decode (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 scan_en,
  input  wire logic [7:0]           scan_byte,
  output ps2sc_pkg::dec_push_t      push_info,
  output logic                      shift_down,
  output logic                      ctrl_down,
  output logic                      alt_down
);

  logic        ext_pending, ext_pending_next;
  logic        shift_state, shift_state_next;
  logic        ctrl_state, ctrl_state_next;
  logic        alt_state, alt_state_next;
  logic [7:0]  code;
  logic        released;
  logic        is_mod;
  logic [15:0] entry;
  logic        keep;
  logic        two;

  assign released = scan_byte[7];
  assign code     = {ext_pending, scan_byte[6:0]};
  // extended codes have bit 7 set, so they never match a modifier
  assign is_mod   = (code == {1'b0, ps2sc_pkg::CODE_LSHIFT})
                 || (code == {1'b0, ps2sc_pkg::CODE_RSHIFT})
                 || (code == {1'b0, ps2sc_pkg::CODE_ALT})
                 || (code == {1'b0, ps2sc_pkg::CODE_CTRL});
  assign entry    = ps2sc_pkg::rom_entry(shift_state, code);
  assign keep     = (entry != 16'h0) && (entry[15:9] != 7'h7F);
  assign two      = |entry[15:12];

  always_comb begin
    push_info = '0;
    ext_pending_next = ext_pending;
    shift_state_next = shift_state;
    ctrl_state_next  = ctrl_state;
    alt_state_next   = alt_state;
    if (scan_byte == ps2sc_pkg::CODE_EXT) begin
      ext_pending_next = 1'b1;
    end else begin
      ext_pending_next = 1'b0;
      if (code == {1'b0, ps2sc_pkg::CODE_LSHIFT} || code == {1'b0, ps2sc_pkg::CODE_RSHIFT}) begin
        shift_state_next = !released;
      end else if (code == {1'b0, ps2sc_pkg::CODE_ALT}) begin
        alt_state_next = !released;
      end else if (code == {1'b0, ps2sc_pkg::CODE_CTRL}) begin
        ctrl_state_next = !released;
      end
      if (!is_mod && !released && keep) begin
        push_info.count  = two ? 2'd2 : 2'd1;
        push_info.first  = two ? ps2sc_pkg::CHAR_PREFIX : entry[7:0];
        push_info.second = entry[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_pending <= 1'b0;
      shift_state <= 1'b0;
      ctrl_state  <= 1'b0;
      alt_state   <= 1'b0;
    end else if (scan_en) begin
      ext_pending <= ext_pending_next;
      shift_state <= shift_state_next;
      ctrl_state  <= ctrl_state_next;
      alt_state   <= alt_state_next;
    end
  end

  assign shift_down = shift_state;
  assign ctrl_down  = ctrl_state;
  assign alt_down   = alt_state;

endmodule
`default_nettype wire

// ----- hw/rtl/ps2sc_ring.sv -----
// Character ring: one-port-write, registered-read memory with indices
`default_nettype none
module ps2sc_ring #(
  parameter int RING_DEPTH = ps2sc_pkg::RING_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ps2sc_pkg::ring_req_t  req,
  output ps2sc_pkg::ring_stat_t      stat,
  output logic [7:0]                 rd_data
);

  localparam int IW = $clog2(RING_DEPTH);

  logic [7:0]    mem [0:RING_DEPTH-1];
  logic [IW-1:0] write_index, read_index;
  logic [IW-1:0] wr_inc, rd_inc;

  assign wr_inc     = (write_index == IW'(RING_DEPTH - 1)) ? '0 : write_index + 1'b1;
  assign rd_inc     = (read_index  == IW'(RING_DEPTH - 1)) ? '0 : read_index + 1'b1;
  assign stat.full  = (wr_inc == read_index);
  assign stat.empty = (write_index == read_index);

  always_ff @(posedge clk) begin
    if (req.push && !stat.full) begin
      mem[write_index] <= req.push_data;
    end
    if (req.pop && !stat.empty) begin
      rd_data <= mem[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
    end else begin
      if (req.push && !stat.full) begin
        write_index <= wr_inc;
      end
      if (req.pop && !stat.empty) begin
        read_index <= rd_inc;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ps2sc_checker.sv -----
// Port-level checker for the scancode decoder and its bind
`default_nettype none
module ps2sc_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire ps2sc_pkg::ps2sc_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted in back-to-back cycles");

  a_pop_no_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_valid |-> out_data.pushed_count == 2'd0 && !out_data.dropped)
    else $error("read result reports a push");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.read_valid |-> out_data.read_char == 8'h00)
    else $error("character without read_valid");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pushed_count != 2'd3)
    else $error("pushed_count out of range");

endmodule

bind ps2_scancode_to_char_fifo ps2sc_checker u_ps2sc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ----- dv/testbench.sv -----
// Testbench for the PS/2 scancode decoder and character ring
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ps2sc_pkg::ps2sc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ps2sc_pkg::ps2sc_out_t out_data;

  ps2_scancode_to_char_fifo #(.RING_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted decoder and ring state
  logic [7:0] ring_mem [0:DEPTH-1];
  int unsigned wr_ptr, rd_ptr;
  logic ext_armed, shift_held, ctrl_held, alt_held;
  ps2sc_pkg::ps2sc_out_t expected_q[$];

  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic int unsigned ring_fill();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  // Table lookup written out from the decoder tables (codes 92 and up are shared)
  function automatic logic [15:0] key_entry(input logic shifted, input logic [7:0] code);
    if (code < 8'(ps2sc_pkg::TABLE_LEN))
      return shifted ? ps2sc_pkg::LOW_SHIFTED[code[6:0]] : ps2sc_pkg::LOW_PLAIN[code[6:0]];
    case (code)
      8'hC8: return 16'hF072;
      8'hCB: return 16'hF04B;
      8'hCD: return 16'hF077;
      8'hD0: return 16'hF080;
      default: return 16'hFE00 + {8'h00, code - 8'(ps2sc_pkg::TABLE_LEN)};
    endcase
  endfunction

  function automatic logic store_char(input logic [7:0] ch);
    int unsigned nxt;
    nxt = (wr_ptr + 1) % DEPTH;
    if (nxt == rd_ptr) return 1'b0;
    ring_mem[wr_ptr] = ch;
    wr_ptr = nxt;
    return 1'b1;
  endfunction

  function automatic ps2sc_pkg::ps2sc_out_t decode_item(input ps2sc_pkg::ps2sc_in_t item);
    ps2sc_pkg::ps2sc_out_t r;
    logic [7:0] code;
    logic rel, ok;
    logic [15:0] e;
    r = '0;
    case (ps2sc_pkg::op_t'(item.operation))
      ps2sc_pkg::OP_SCAN: begin
        if (item.data_byte == ps2sc_pkg::CODE_EXT) begin
          ext_armed = 1'b1;
        end else begin
          rel = item.data_byte[7];
          code = {ext_armed, item.data_byte[6:0]};
          ext_armed = 1'b0;
          if (code == {1'b0, ps2sc_pkg::CODE_LSHIFT} ||
              code == {1'b0, ps2sc_pkg::CODE_RSHIFT}) begin
            shift_held = !rel;
          end else if (code == {1'b0, ps2sc_pkg::CODE_ALT}) begin
            alt_held = !rel;
          end else if (code == {1'b0, ps2sc_pkg::CODE_CTRL}) begin
            ctrl_held = !rel;
          end else if (!rel) begin
            e = key_entry(shift_held, code);
            if (e != 16'h0 && e[15:9] != 7'h7F) begin
              if (e[15:12] != 4'h0) begin
                ok = store_char(ps2sc_pkg::CHAR_PREFIX);
                r.pushed_count = r.pushed_count + {1'b0, ok};
                r.dropped = r.dropped | !ok;
              end
              ok = store_char(e[7:0]);
              r.pushed_count = r.pushed_count + {1'b0, ok};
              r.dropped = r.dropped | !ok;
            end
          end
        end
      end
      ps2sc_pkg::OP_PUSH: begin
        ok = store_char(item.data_byte);
        r.pushed_count = {1'b0, ok};
        r.dropped = !ok;
      end
      ps2sc_pkg::OP_POP: begin
        if (rd_ptr != wr_ptr) begin
          r.read_char = ring_mem[rd_ptr];
          r.read_valid = 1'b1;
          rd_ptr = (rd_ptr + 1) % DEPTH;
        end
      end
      default: ;
    endcase
    r.shift_down = shift_held;
    r.ctrl_down = ctrl_held;
    r.alt_down = alt_held;
    return r;
  endfunction

  // Send one item; prediction is made at the transfer edge.
  // in_valid stays high into the next item unless the sender idles.
  task automatic send_item(input ps2sc_pkg::op_t op, input logic [7:0] b);
    ps2sc_pkg::ps2sc_in_t item;
    item = '{operation: op, data_byte: b};
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(decode_item(item));
  endtask

  // Receiver stall and result checker
  always @(posedge clk) begin
    ps2sc_pkg::ps2sc_out_t exp_r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no expectation: %p", out_data);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data.read_char !== exp_r.read_char) begin
            $error("read_char exp %h got %h", exp_r.read_char, out_data.read_char); errors++;
          end
          if (out_data.read_valid !== exp_r.read_valid) begin
            $error("read_valid exp %b got %b", exp_r.read_valid, out_data.read_valid); errors++;
          end
          if (out_data.pushed_count !== exp_r.pushed_count) begin
            $error("pushed_count exp %0d got %0d", exp_r.pushed_count,
                   out_data.pushed_count); errors++;
          end
          if (out_data.dropped !== exp_r.dropped) begin
            $error("dropped exp %b got %b", exp_r.dropped, out_data.dropped); errors++;
          end
          if (out_data.shift_down !== exp_r.shift_down) begin
            $error("shift_down exp %b got %b", exp_r.shift_down, out_data.shift_down); errors++;
          end
          if (out_data.ctrl_down !== exp_r.ctrl_down) begin
            $error("ctrl_down exp %b got %b", exp_r.ctrl_down, out_data.ctrl_down); errors++;
          end
          if (out_data.alt_down !== exp_r.alt_down) begin
            $error("alt_down exp %b got %b", exp_r.alt_down, out_data.alt_down); errors++;
          end
        end
      end
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: counts cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Directed: extremes, every operation, modifiers, extended keys, empty pop
  task automatic test_directed();
    send_item(ps2sc_pkg::OP_POP, 8'h00);          // empty read
    send_item(ps2sc_pkg::OP_NONE, 8'hFF);         // unused operation
    send_item(ps2sc_pkg::OP_SCAN, 8'h00);         // zero entry
    send_item(ps2sc_pkg::OP_SCAN, 8'h1E);         // 'a'
    send_item(ps2sc_pkg::OP_SCAN, {1'b0, ps2sc_pkg::CODE_LSHIFT});
    send_item(ps2sc_pkg::OP_SCAN, 8'h1E);         // 'A'
    // other shift key releases shared flag
    send_item(ps2sc_pkg::OP_SCAN, {1'b1, ps2sc_pkg::CODE_RSHIFT});
    send_item(ps2sc_pkg::OP_SCAN, {1'b0, ps2sc_pkg::CODE_CTRL});
    send_item(ps2sc_pkg::OP_SCAN, {1'b0, ps2sc_pkg::CODE_ALT});
    send_item(ps2sc_pkg::OP_SCAN, 8'h3B);         // F1, two-byte entry
    send_item(ps2sc_pkg::OP_SCAN, ps2sc_pkg::CODE_EXT);
    send_item(ps2sc_pkg::OP_SCAN, 8'h48);         // extended up arrow
    send_item(ps2sc_pkg::OP_SCAN, ps2sc_pkg::CODE_EXT);
    // extended never matches a modifier
    send_item(ps2sc_pkg::OP_SCAN, {1'b0, ps2sc_pkg::CODE_ALT});
    send_item(ps2sc_pkg::OP_SCAN, 8'h9E);         // release of a plain key
    send_item(ps2sc_pkg::OP_SCAN, 8'hB8);         // alt release
    send_item(ps2sc_pkg::OP_SCAN, 8'h9D);         // ctrl release
    send_item(ps2sc_pkg::OP_SCAN, ps2sc_pkg::CODE_EXT);
    send_item(ps2sc_pkg::OP_SCAN, 8'h7F);         // dropped 0xFE entry
    send_item(ps2sc_pkg::OP_PUSH, 8'hFF);
    send_item(ps2sc_pkg::OP_PUSH, 8'h00);
    repeat (4) send_item(ps2sc_pkg::OP_POP, 8'hFF);
  endtask

  // Fill the ring to full and past it, then drain it
  task automatic test_full_ring();
    while (ring_fill() < DEPTH - 2) send_item(ps2sc_pkg::OP_PUSH, 8'($urandom));
    send_item(ps2sc_pkg::OP_SCAN, 8'h3C);         // first byte stored, second lost
    send_item(ps2sc_pkg::OP_PUSH, 8'hA5);         // lost
    send_item(ps2sc_pkg::OP_SCAN, 8'h1E);         // lost
    while (ring_fill() != 0) send_item(ps2sc_pkg::OP_POP, 8'($urandom));
  endtask

  // Random traffic: key sequences, shift presses and releases, pushes, pops and noise
  task automatic test_random(input int n);
    int k;
    logic [7:0] sc;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          sc = 8'($urandom_range(1, 91));
          if ($urandom_range(3) == 0) send_item(ps2sc_pkg::OP_SCAN, ps2sc_pkg::CODE_EXT);
          send_item(ps2sc_pkg::OP_SCAN, sc);
          send_item(ps2sc_pkg::OP_SCAN, sc | 8'h80);
          k += 2;
        end
        3: send_item(ps2sc_pkg::OP_SCAN, $urandom_range(1) ? {1'b0, ps2sc_pkg::CODE_LSHIFT}
                                                          : {1'b1, ps2sc_pkg::CODE_RSHIFT});
        4: send_item(ps2sc_pkg::OP_SCAN, 8'($urandom));
        5: send_item(ps2sc_pkg::OP_PUSH, 8'($urandom));
        6, 7, 8: send_item(ps2sc_pkg::OP_POP, 8'($urandom));
        default: send_item(ps2sc_pkg::op_t'(2'($urandom_range(3))), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    wr_ptr = 0; rd_ptr = 0;
    ext_armed = 0; shift_held = 0; ctrl_held = 0; alt_held = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_ring();
    test_random(450);
    send_idle_pct = 67;
    test_random(450);
    send_idle_pct = 0; recv_stall_pct = 67;
    test_full_ring();
    test_random(450);
    send_idle_pct = 10; recv_stall_pct = 10;
    test_random(450);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
